// ===== src/stq_pkg.sv =====
package stq_pkg;

    localparam int HANDLE_W = 4;
    localparam int TIME_W   = 64;
    localparam int WAIT_W   = 32;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_POP,
        OP_QUERY
    } t_op;

    typedef enum logic [2:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_NOT_FOUND,
        ST_DUPLICATE
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_LOAD
    } t_cell_cmd;

    typedef struct packed {
        logic later;
        logic match;
    } t_cell_flags;

endpackage

// ===== src/stq_req_if.sv =====
interface stq_req_if import stq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [HANDLE_W-1:0] timer_handle;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   current_time;

    modport source (
        output valid, operation, timer_handle, deadline, current_time,
        input  ready
    );
    modport sink (
        input  valid, operation, timer_handle, deadline, current_time,
        output ready
    );
endinterface

// ===== src/stq_rsp_if.sv =====
interface stq_rsp_if import stq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [HANDLE_W-1:0] popped_handle;
    logic [TIME_W-1:0]   popped_deadline;
    logic [WAIT_W-1:0]   wait_time;

    modport source (
        output valid, status, popped_handle, popped_deadline, wait_time,
        input  ready
    );
    modport sink (
        input  valid, status, popped_handle, popped_deadline, wait_time,
        output ready
    );
endinterface

// ===== src/stq_cell.sv =====
module stq_cell import stq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_cmp,
    input  logic        i_occupied,
    input  t_entry      i_key,
    input  t_cell_cmd   i_cmd,
    input  t_entry      i_left,
    input  t_entry      i_right,
    output t_entry      o_entry,
    output t_cell_flags o_flags
);

    t_entry      r_entry;
    t_entry      n_entry;
    t_cell_flags r_flags;
    t_cell_flags n_flags;

    always_comb begin
        n_flags.later = !i_occupied || (i_key.deadline < r_entry.deadline);
        n_flags.match = i_occupied && (i_key.handle == r_entry.handle);
    end

    always_comb begin
        case (i_cmd)
            CELL_TAKE_LEFT:  n_entry = i_left;
            CELL_TAKE_RIGHT: n_entry = i_right;
            CELL_LOAD:       n_entry = i_key;
            default:         n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_cmp) begin
            r_flags <= n_flags;
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

// ===== src/sorted_timer_queue_unit.sv =====
// An accepted request is compared in every cell in S_CMP, then applied in
// S_UPD, where the cell chain shifts by at most one position and the response
// is registered once the slot is free. New requests enter in idle or at commit.
// Reset (synchronous, active low) empties the queue and the response slot;
// no clearing pass is needed, cell contents are ignored beyond the count.
module sorted_timer_queue_unit import stq_pkg::*; #(
    parameter int QUEUE_ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stq_req_if.sink   i_req,
    stq_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(QUEUE_ENTRIES + 1);
    localparam int LVLS  = $clog2(QUEUE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    t_entry              r_key;
    logic [TIME_W-1:0]   r_now;
    logic [CNT_W-1:0]    r_count;
    logic                r_due;
    logic [WAIT_W-1:0]   r_wait;
    logic                r_out_valid;
    t_status             r_status;
    logic [HANDLE_W-1:0] r_p_handle;
    logic [TIME_W-1:0]   r_p_deadline;
    logic [WAIT_W-1:0]   r_wait_out;

    t_entry      w_entry [QUEUE_ENTRIES];
    t_cell_flags w_flags [QUEUE_ENTRIES];
    t_cell_cmd   w_cmd   [QUEUE_ENTRIES];

    logic [QUEUE_ENTRIES-1:0] later_vec;
    logic [QUEUE_ENTRIES-1:0] later_prev;
    logic [QUEUE_ENTRIES-1:0] match_vec;
    logic [QUEUE_ENTRIES-1:0] pre_vec;

    logic    out_free;
    logic    commit;
    logic    accept;
    logic    found;
    logic    empty;
    logic    full;
    logic    pop_ok;
    logic    query_ok;
    t_status status;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign commit      = (r_state == S_UPD) && out_free;
    assign i_req.ready = (r_state == S_IDLE) || commit;
    assign accept      = i_req.valid && i_req.ready;

    genvar g;
    generate
        for (g = 0; g < QUEUE_ENTRIES; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            if (g == 0) begin : g_first
                assign w_left = w_entry[0];
            end else begin : g_mid
                assign w_left = w_entry[g-1];
            end
            if (g == QUEUE_ENTRIES - 1) begin : g_last
                assign w_right = w_entry[g];
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            stq_cell u_cell (
                .i_clk      (i_clk),
                .i_cmp      (r_state == S_CMP),
                .i_occupied (CNT_W'(g) < r_count),
                .i_key      (r_key),
                .i_cmd      (w_cmd[g]),
                .i_left     (w_left),
                .i_right    (w_right),
                .o_entry    (w_entry[g]),
                .o_flags    (w_flags[g])
            );

            assign later_vec[g] = w_flags[g].later;
            assign match_vec[g] = w_flags[g].match;
        end
    endgenerate

    assign later_prev = {later_vec[QUEUE_ENTRIES-2:0], 1'b0};

    // parallel prefix OR: cells at or behind the removed entry
    always_comb begin
        pre_vec = match_vec;
        for (int l = 0; l < LVLS; l++) begin
            pre_vec = pre_vec | (pre_vec << (1 << l));
        end
    end

    assign found = |match_vec;
    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(QUEUE_ENTRIES));

    always_comb begin
        case (r_op)
            OP_ADD:    status = found ? ST_DUPLICATE : (full ? ST_FULL : ST_OK);
            OP_REMOVE: status = found ? ST_OK : ST_NOT_FOUND;
            OP_POP:    status = (empty || !r_due) ? ST_EMPTY : ST_OK;
            default:   status = empty ? ST_EMPTY : ST_OK;
        endcase
    end

    assign pop_ok   = (r_op == OP_POP) && (status == ST_OK);
    assign query_ok = (r_op == OP_QUERY) && (status == ST_OK);

    always_comb begin
        for (int i = 0; i < QUEUE_ENTRIES; i++) begin
            w_cmd[i] = CELL_HOLD;
            if (commit && status == ST_OK) begin
                case (r_op)
                    OP_ADD: begin
                        if (later_prev[i]) begin
                            w_cmd[i] = CELL_TAKE_LEFT;
                        end else if (later_vec[i]) begin
                            w_cmd[i] = CELL_LOAD;
                        end
                    end
                    OP_REMOVE: begin
                        if (pre_vec[i]) begin
                            w_cmd[i] = CELL_TAKE_RIGHT;
                        end
                    end
                    OP_POP:  w_cmd[i] = CELL_TAKE_RIGHT;
                    default: w_cmd[i] = CELL_HOLD;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                    r_due   <= (r_now >= w_entry[0].deadline);
                    r_wait  <= w_entry[0].deadline[WAIT_W-1:0] - r_now[WAIT_W-1:0];
                end
                S_UPD: begin
                    if (commit) begin
                        r_state <= accept ? S_CMP : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (accept) begin
                r_op             <= t_op'(i_req.operation);
                r_key.handle     <= i_req.timer_handle;
                r_key.deadline   <= i_req.deadline;
                r_now            <= i_req.current_time;
            end

            if (commit) begin
                r_out_valid  <= 1'b1;
                r_status     <= status;
                r_p_handle   <= pop_ok ? w_entry[0].handle : '0;
                r_p_deadline <= pop_ok ? w_entry[0].deadline : '0;
                r_wait_out   <= query_ok ? r_wait : '0;
                if (status == ST_OK) begin
                    if (r_op == OP_ADD) begin
                        r_count <= r_count + CNT_W'(1);
                    end else if (r_op == OP_REMOVE || r_op == OP_POP) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.popped_handle   = r_p_handle;
    assign o_rsp.popped_deadline = r_p_deadline;
    assign o_rsp.wait_time       = r_wait_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_ENTRIES))
        else $error("entry count above capacity");

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_CMP)
        else $error("accepted request not compared next cycle");

    a_rsp_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("response raised outside update cycle");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_op == OP_ADD && status == ST_OK)
            |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("successful add did not grow the queue");

endmodule
